// ===== rtl/vca_pkg.sv =====
// Package for the visibility channel averager.
// Shared types, register indexes and lane constants; no dependencies.
package vca_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 32;
    localparam int NUM_LANES = 8;
    localparam int UV_W      = 32;
    localparam int CUT_W     = 31;

    // register indexes on the configuration port
    localparam logic [2:0] REG_NUM_CH   = 3'd0;
    localparam logic [2:0] REG_MIN_CUT  = 3'd1;
    localparam logic [2:0] REG_MAX_CUT  = 3'd2;
    localparam logic [2:0] REG_TAPER_EN = 3'd3;
    localparam logic [2:0] REG_TAPER_SC = 3'd4;

    // result flag codes
    localparam logic [1:0] CODE_GOOD    = 2'd0;
    localparam logic [1:0] CODE_ALLFLAG = 2'd1;
    localparam logic [1:0] CODE_PARTIAL = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_step;
    } t_lane_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_WAIT,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        UV_IDLE,
        UV_SQ,
        UV_SUM,
        UV_ROOT,
        UV_SCALE,
        UV_DONE
    } t_uv_state;

endpackage

// ===== rtl/vca_lane.sv =====
// One product lane: channel accumulator, bit-serial divider and taper multiply.
// Depends on vca_pkg.
module vca_lane #(
    parameter int GW = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic                            i_last,
    input  logic signed [vca_pkg::SAMPLE_W-1:0] i_sample,
    input  vca_pkg::t_lane_ctl              i_ctl,
    input  logic [GW-1:0]                   i_good,
    input  logic                            i_taper_en,
    input  logic                            i_t_sat,
    input  logic [31:0]                     i_t,
    input  logic                            i_row_good,
    output logic [vca_pkg::SUM_W-1:0]       o_res
);
    import vca_pkg::*;

    logic [SUM_W-1:0] r_acc, n_acc;
    logic [SUM_W-1:0] r_sum;
    logic             r_neg;
    logic [SUM_W-1:0] r_dvd;
    logic [GW-1:0]    r_rem;
    logic [SUM_W-1:0] r_res;
    logic [GW:0]      trial;
    logic             qbit;
    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0] tap, mag;

    always_comb begin
        n_acc = r_acc + (i_acc ? SUM_W'(i_sample) : '0);
        trial = {r_rem, r_dvd[SUM_W-1]};
        qbit  = (trial >= {1'b0, i_good});
        prod  = r_dvd * i_t;
        tap   = i_t_sat ? r_dvd : prod[2*SUM_W-1:SUM_W];
        mag   = i_taper_en ? tap : r_dvd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_last) begin
            r_acc <= '0;
        end else if (i_acc) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_last) begin
            r_sum <= n_acc;
        end
        if (i_ctl.load) begin
            r_neg <= r_sum[SUM_W-1];
            r_dvd <= r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_rem <= qbit ? GW'(trial - {1'b0, i_good}) : trial[GW-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], qbit};
        end
        if (i_ctl.mul_step) begin
            r_res <= i_row_good ? (r_neg ? (~mag + 1'b1) : mag) : r_sum;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/vca_uv.sv =====
// uv distance unit: squares, cut test, iterative square root and taper factor.
// Depends on vca_pkg.
module vca_uv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [vca_pkg::UV_W-1:0] i_u,
    input  logic signed [vca_pkg::UV_W-1:0] i_v,
    input  logic [vca_pkg::CUT_W-1:0]     i_min,
    input  logic [vca_pkg::CUT_W-1:0]     i_max,
    input  logic [31:0]                   i_scale,
    output logic                          o_done,
    output logic                          o_cut,
    output logic [31:0]                   o_t,
    output logic                          o_t_sat
);
    import vca_pkg::*;

    t_uv_state r_state, n_state;
    logic [31:0] r_au, r_av;
    logic [63:0] r_pa, r_pb, r_mn2, r_mx2;
    logic [63:0] r_x, r_r, r_bit, r_tp;
    logic [4:0]  r_cnt;
    logic        r_cut;
    logic [63:0] d2, rb;
    logic        take;

    always_comb begin
        d2   = r_pa + r_pb;
        rb   = r_r + r_bit;
        take = (r_x >= rb);
        n_state = r_state;
        unique case (r_state)
            UV_IDLE, UV_DONE: if (i_start) n_state = UV_SQ;
            UV_SQ:            n_state = UV_SUM;
            UV_SUM:           n_state = UV_ROOT;
            UV_ROOT:          if (r_cnt == 5'd31) n_state = UV_SCALE;
            UV_SCALE:         n_state = UV_DONE;
            default:          n_state = UV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= UV_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == UV_IDLE || r_state == UV_DONE) && i_start) begin
            r_au <= i_u[UV_W-1] ? (~i_u + 1'b1) : i_u;
            r_av <= i_v[UV_W-1] ? (~i_v + 1'b1) : i_v;
        end
        if (r_state == UV_SQ) begin
            r_pa  <= r_au * r_au;
            r_pb  <= r_av * r_av;
            r_mn2 <= 64'(i_min) * 64'(i_min);
            r_mx2 <= 64'(i_max) * 64'(i_max);
        end
        if (r_state == UV_SUM) begin
            r_x   <= d2;
            r_r   <= '0;
            r_bit <= 64'd1 << 62;
            r_cnt <= '0;
            r_cut <= (d2 < r_mn2) || (d2 > r_mx2);
        end
        if (r_state == UV_ROOT) begin
            if (take) begin
                r_x <= r_x - rb;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == UV_SCALE) begin
            r_tp <= r_r[31:0] * i_scale;
        end
    end

    assign o_done  = (r_state == UV_DONE);
    assign o_cut   = r_cut;
    assign o_t     = r_tp[31:0];
    // factor of one or more: product of 2^32 and above
    assign o_t_sat = |r_tp[63:32];

endmodule

// ===== rtl/visibility_channel_averager_unit.sv =====
// Top level of the visibility channel averager: stream ports, config registers,
// row control, eight product lanes and the uv unit. Depends on vca_pkg, vca_lane, vca_uv.
//
// Usage: channel samples of a baseline row arrive one beat per cycle on the s_axis
// channel; tuser carries is_auto and chan_flag. Row attributes (u, v, is_auto) are
// taken from the first channel. After the last channel of a cross-correlation row
// one result beat goes out on m_axis: flag code in tuser, eight 32-bit products in
// tdata. Autocorrelation rows give no beat.
// A result is produced once the 32-step bit-serial divide in each lane and the
// 32-step square root in the uv unit are done. Samples stream at one beat per
// cycle; the last beat of a row is held off while the previous row is still in
// the back stage or its result is not yet taken.
// Reset clears sums, counts and row state and loads register defaults.
// When the receiver stalls, the result stays on m_axis and intake continues
// until the next row's last beat.
// Registers (APB, byte address 4*i): num_channels, min_uv_cut, max_uv_cut,
// taper_enable, taper_scale. Write them only while the block is idle.
module visibility_channel_averager_unit #(
    parameter int MAX_CHANNELS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // u_coord, v_coord, xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im
    input  logic [255:0] i_s_axis_tdata,
    // is_auto, chan_flag
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // xx_re_avg, xx_im_avg, xy_re_avg, xy_im_avg, yx_re_avg, yx_im_avg, yy_re_avg, yy_im_avg
    output logic [255:0] o_m_axis_tdata,
    // flag_code
    output logic [1:0]   o_m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vca_pkg::*;

    localparam int NW = $clog2(MAX_CHANNELS + 1);
    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = ((NW > 9) ? NW : 9) + 1;

    // configuration
    logic [8:0]       r_num_ch;
    logic [CUT_W-1:0] r_min_cut, r_max_cut;
    logic             r_taper_en;
    logic [31:0]      r_taper_sc;
    logic [2:0]       reg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch   <= 9'd1;
            r_min_cut  <= '0;
            r_max_cut  <= CUT_W'(1600000000);
            r_taper_en <= 1'b0;
            r_taper_sc <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NUM_CH:   r_num_ch   <= pwdata[8:0];
                REG_MIN_CUT:  r_min_cut  <= pwdata[CUT_W-1:0];
                REG_MAX_CUT:  r_max_cut  <= pwdata[CUT_W-1:0];
                REG_TAPER_EN: r_taper_en <= pwdata[0];
                REG_TAPER_SC: r_taper_sc <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUM_CH:   prdata = 32'(r_num_ch);
            REG_MIN_CUT:  prdata = 32'(r_min_cut);
            REG_MAX_CUT:  prdata = 32'(r_max_cut);
            REG_TAPER_EN: prdata = 32'(r_taper_en);
            REG_TAPER_SC: prdata = r_taper_sc;
            default:      prdata = '0;
        endcase
    end

    // effective channel count: zero acts as one, clamp at MAX_CHANNELS
    logic [CW-1:0] n_eff;
    always_comb begin
        n_eff = CW'(r_num_ch);
        if (r_num_ch == 9'd0) n_eff = CW'(1);
        if (n_eff > CW'(MAX_CHANNELS)) n_eff = CW'(MAX_CHANNELS);
    end

    // row front end
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [NW-1:0] r_good, good_next, r_gsnap;
    logic          r_auto, cur_auto;
    logic [UV_W-1:0] r_u, r_v, cur_u, cur_v;
    logic          is_last, busy, acc, row_end, emit_row;
    logic [5:0]    r_cnt;
    logic          r_row_good;
    logic [1:0]    r_code;
    t_lane_ctl     lane_ctl;
    logic          uv_done, uv_cut, uv_t_sat;
    logic [31:0]   uv_t;

    assign busy     = (r_state != S_IDLE);
    assign is_last  = (CW'(r_idx) + CW'(1)) >= n_eff;
    assign o_s_axis_tready = !(busy && is_last);
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign row_end  = acc && is_last;
    assign cur_auto = (r_idx == '0) ? i_s_axis_tuser[0] : r_auto;
    assign cur_u    = (r_idx == '0) ? i_s_axis_tdata[31:0] : r_u;
    assign cur_v    = (r_idx == '0) ? i_s_axis_tdata[63:32] : r_v;
    assign good_next = r_good + NW'(!i_s_axis_tuser[1]);
    assign emit_row = row_end && !cur_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_good <= '0;
            r_auto <= 1'b0;
            r_u    <= '0;
            r_v    <= '0;
        end else if (acc) begin
            r_auto <= cur_auto;
            r_u    <= cur_u;
            r_v    <= cur_v;
            if (is_last) begin
                r_idx  <= '0;
                r_good <= '0;
            end else begin
                r_idx  <= r_idx + 1'b1;
                r_good <= good_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_row) begin
            r_gsnap    <= good_next;
            r_row_good <= CW'(good_next) > (n_eff >> 1);
        end
    end

    // back stage sequencer
    always_comb begin
        n_state  = r_state;
        lane_ctl = '0;
        unique case (r_state)
            S_IDLE: if (emit_row) n_state = S_LOAD;
            S_LOAD: begin
                lane_ctl.load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                lane_ctl.div_step = 1'b1;
                if (r_cnt == 6'd31) n_state = S_WAIT;
            end
            S_WAIT: if (uv_done) n_state = S_MUL;
            S_MUL: begin
                lane_ctl.mul_step = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) r_cnt <= r_cnt + 1'b1;
            else                  r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            if (uv_cut)              r_code <= CODE_PARTIAL;
            else if (r_row_good)     r_code <= CODE_GOOD;
            else if (r_gsnap == '0)  r_code <= CODE_ALLFLAG;
            else                     r_code <= CODE_PARTIAL;
        end
    end

    vca_uv u_uv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (emit_row),
        .i_u     (cur_u),
        .i_v     (cur_v),
        .i_min   (r_min_cut),
        .i_max   (r_max_cut),
        .i_scale (r_taper_sc),
        .o_done  (uv_done),
        .o_cut   (uv_cut),
        .o_t     (uv_t),
        .o_t_sat (uv_t_sat)
    );

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        vca_lane #(
            .GW (NW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_acc      (acc && !i_s_axis_tuser[1]),
            .i_last     (row_end),
            .i_sample   (i_s_axis_tdata[64 + SAMPLE_W*k +: SAMPLE_W]),
            .i_ctl      (lane_ctl),
            .i_good     (r_gsnap),
            .i_taper_en (r_taper_en),
            .i_t_sat    (uv_t_sat),
            .i_t        (uv_t),
            .i_row_good (r_row_good),
            .o_res      (o_m_axis_tdata[SUM_W*k +: SUM_W])
        );
    end

    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tuser  = r_code;

endmodule
